[rtl/core/swna_pkg.sv]
// ----------------------------------------------------------------------------
// swna_pkg
// Shared types and constants for the stall watchdog with nearest alarm light.
// ----------------------------------------------------------------------------
package swna_pkg;

    // Input opcodes (carried on s_tuser)
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TICK   = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    // Relay actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_OFF  = 2'd2;

    // Field widths
    localparam int BLOCK_W  = 16;
    localparam int COORD_W  = 24;
    localparam int LIMIT_W  = 16;
    localparam int RELAY_W  = 4;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 1;

    // Configuration registers (word index from paddr[2])
    localparam logic REG_STALL_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] STALL_LIMIT_RESET = 16'd200;

    // Controller to datapath
    typedef struct packed {
        logic load;          // latch accepted input transaction
        logic clear;         // empty the light table
        logic append;        // store one light position
        logic stall_upd;     // update stall counter for a tick
        logic search_start;  // rewind the search index
        logic issue;         // read next table entry into the distance pipe
        logic emit;          // form result, load output register
    } swna_cmd_t;

    // Datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    abnormal;
        logic    lights_nonzero;
        logic    last_issue;
        logic    pipe_empty;
        logic    out_free;
    } swna_status_t;

endpackage

[rtl/core/stall_watchdog_nearest_alarm.sv]
// ----------------------------------------------------------------------------
// stall_watchdog_nearest_alarm
// Vehicle stall watchdog that switches the relay of the nearest alarm light.
// ----------------------------------------------------------------------------
// One transaction at a time. Clear and append pass from decode back to idle
// before the next transaction can be accepted; opcode 3 is dropped the same
// way. A tick passes through decode and evaluate to the result state; when
// it is abnormal with lights in the table, a search and a drain come between:
// the search reads one table entry per cycle through a 4-stage distance
// pipeline (table read, difference/abs, two 24x24 squarers, sum), and the
// compare takes the output of the last stage. Each tick returns exactly one
// result on the m_ side; clear and append return none. The result sits in an
// output register, so a new transaction is taken while it waits for m_tready;
// only a second result finding the register still full stalls the sequencer.
// stall_limit is written through the APB port at byte address 0 (paddr[2]
// selects the register word) and must only be changed while the block idles.
// The light table has no reset; only entries below the fill count are read.
// ----------------------------------------------------------------------------
module stall_watchdog_nearest_alarm
    import swna_pkg::*;
#(
    parameter int MAX_LIGHTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [15:0] block_id, [39:16] pos_x, [63:40] pos_y
    input  logic [1:0]  s_tuser,   // [1:0] opcode

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] abnormal, [2:1] relay_action,
                                   // [6:3] relay_number, [7] zero

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    swna_cmd_t            cmd;
    swna_status_t         status;
    logic [LIMIT_W-1:0]   stall_limit_reg;
    logic                 out_abnormal;
    logic [1:0]           out_relay_action;
    logic [RELAY_W-1:0]   out_relay_number;

    // APB: zero wait states, write lands in the access phase
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_limit_reg <= STALL_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_STALL_LIMIT) begin
            stall_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_STALL_LIMIT) ? {16'd0, stall_limit_reg} : 32'd0;

    swna_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swna_datapath #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .stall_limit      (stall_limit_reg),
        .in_op            (opcode_t'(s_tuser)),
        .in_block_id      (s_tdata[15:0]),
        .in_pos_x         (s_tdata[39:16]),
        .in_pos_y         (s_tdata[63:40]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_abnormal     (out_abnormal),
        .out_relay_action (out_relay_action),
        .out_relay_number (out_relay_number)
    );

    assign m_tdata = {1'b0, out_relay_number, out_relay_action, out_abnormal};

endmodule

[rtl/core/swna_datapath.sv]
// ----------------------------------------------------------------------------
// swna_datapath
// Light table, stall counter, distance pipeline, alarm latch, output register.
// ----------------------------------------------------------------------------
module swna_datapath
    import swna_pkg::*;
#(
    parameter int MAX_LIGHTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  swna_cmd_t            cmd,
    output swna_status_t         status,
    input  logic [LIMIT_W-1:0]   stall_limit,
    input  opcode_t              in_op,
    input  logic [BLOCK_W-1:0]   in_block_id,
    input  logic [COORD_W-1:0]   in_pos_x,
    input  logic [COORD_W-1:0]   in_pos_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_abnormal,
    output logic [1:0]           out_relay_action,
    output logic [RELAY_W-1:0]   out_relay_number
);

    localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
    localparam int IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

    // latched input
    opcode_t              op_reg;
    logic [BLOCK_W-1:0]   blk_reg;
    logic [COORD_W-1:0]   px_reg;
    logic [COORD_W-1:0]   py_reg;

    // tick state
    logic [LIMIT_W-1:0]   stall_count_reg;
    logic [LIMIT_W-1:0]   stall_count_next;
    logic [BLOCK_W-1:0]   last_block_reg;
    logic                 alarm_latched_reg;
    logic [RELAY_W-1:0]   chosen_light_reg;
    logic [LIMIT_W:0]     cap;

    // light table
    logic [2*COORD_W-1:0] mem [MAX_LIGHTS];
    logic [2*COORD_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]     light_count_reg;
    logic                 full;

    // search pipeline
    logic [IDX_W-1:0]     idx_reg;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]     idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic [COORD_W:0]     dx, dy;
    logic [COORD_W:0]     ndx, ndy;
    logic [COORD_W-1:0]   ax_reg, ay_reg;
    logic [SQ_W-1:0]      sqx_reg, sqy_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [DIST_W-1:0]    best_reg;
    logic [IDX_W-1:0]     best_i_reg;
    logic                 found_reg;
    logic                 abnormal;

    // output register
    logic                 out_valid_reg;
    logic                 out_abnormal_reg;
    logic [1:0]           out_action_reg;
    logic [RELAY_W-1:0]   out_number_reg;

    assign full     = (light_count_reg == CNT_W'(MAX_LIGHTS));
    assign abnormal = (stall_count_reg > stall_limit);

    // saturation point: limit + 1, but never above the counter's top
    assign cap = (stall_limit != {LIMIT_W{1'b1}}) ? ({1'b0, stall_limit} + 1'b1)
                                                  : {1'b0, {LIMIT_W{1'b1}}};

    always_comb begin
        if (blk_reg != last_block_reg) begin
            stall_count_next = LIMIT_W'(1);
        end else if ({1'b0, stall_count_reg} < cap) begin
            stall_count_next = stall_count_reg + 1'b1;
        end else begin
            stall_count_next = stall_count_reg;
        end
    end

    // |vehicle - light| per axis; magnitude always fits COORD_W bits
    assign dx  = {px_reg[COORD_W-1], px_reg}
               - {rd_data_reg[COORD_W-1], rd_data_reg[COORD_W-1:0]};
    assign dy  = {py_reg[COORD_W-1], py_reg}
               - {rd_data_reg[2*COORD_W-1], rd_data_reg[2*COORD_W-1:COORD_W]};
    assign ndx = -dx;
    assign ndy = -dy;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            blk_reg <= in_block_id;
            px_reg  <= in_pos_x;
            py_reg  <= in_pos_y;
        end
        // table word: y above x
        if (cmd.append && !full) begin
            mem[light_count_reg[IDX_W-1:0]] <= {py_reg, px_reg};
        end
        rd_data_reg <= mem[idx_reg];

        idx1_reg <= idx_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        ax_reg   <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        ay_reg   <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        dist_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};

        if (cmd.emit) begin
            out_abnormal_reg <= abnormal;
            out_action_reg   <= ACT_NONE;
            out_number_reg   <= '0;
            if (abnormal) begin
                if (found_reg) begin
                    out_action_reg <= ACT_ON;
                    out_number_reg <= RELAY_W'(best_i_reg);
                end
            end else if (alarm_latched_reg) begin
                out_action_reg <= ACT_OFF;
                out_number_reg <= chosen_light_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_count_reg   <= '0;
            stall_count_reg   <= '0;
            last_block_reg    <= '0;
            alarm_latched_reg <= 1'b0;
            chosen_light_reg  <= '0;
            idx_reg           <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            v4_reg            <= 1'b0;
            found_reg         <= 1'b0;
            best_reg          <= '0;
            best_i_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear) begin
                light_count_reg <= '0;
            end else if (cmd.append && !full) begin
                light_count_reg <= light_count_reg + 1'b1;
            end

            if (cmd.stall_upd) begin
                stall_count_reg <= stall_count_next;
                last_block_reg  <= blk_reg;
                found_reg       <= 1'b0;
            end

            if (cmd.search_start) begin
                idx_reg <= '0;
            end else if (cmd.issue) begin
                idx_reg <= idx_reg + 1'b1;
            end

            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            // strict less-than: first of equal distances wins
            if (v4_reg && (!found_reg || dist_reg < best_reg)) begin
                found_reg  <= 1'b1;
                best_reg   <= dist_reg;
                best_i_reg <= idx4_reg;
            end

            if (cmd.emit) begin
                if (abnormal) begin
                    if (found_reg) begin
                        alarm_latched_reg <= 1'b1;
                        chosen_light_reg  <= RELAY_W'(best_i_reg);
                    end
                end else if (alarm_latched_reg) begin
                    alarm_latched_reg <= 1'b0;
                end
            end

            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.op             = op_reg;
    assign status.abnormal       = abnormal;
    assign status.lights_nonzero = (light_count_reg != '0);
    assign status.last_issue     = (CNT_W'(idx_reg) == light_count_reg - 1'b1);
    assign status.pipe_empty     = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign status.out_free       = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_abnormal     = out_abnormal_reg;
    assign out_relay_action = out_action_reg;
    assign out_relay_number = out_number_reg;

endmodule

[rtl/core/swna_ctrl.sv]
// ----------------------------------------------------------------------------
// swna_ctrl
// Sequencer: decodes a transaction, walks the light table, issues the result.
// ----------------------------------------------------------------------------
module swna_ctrl
    import swna_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  swna_status_t status,
    output swna_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EVAL,
        ST_SEARCH,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_valid;
            end
            ST_DECODE: begin
                cmd.clear     = (status.op == OP_CLEAR);
                cmd.append    = (status.op == OP_APPEND);
                cmd.stall_upd = (status.op == OP_TICK);
            end
            ST_EVAL: begin
                cmd.search_start = status.abnormal && status.lights_nonzero;
            end
            ST_SEARCH: begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_RESULT: begin
                cmd.emit = status.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) state_reg <= ST_DECODE;
                end
                ST_DECODE: begin
                    state_reg <= (status.op == OP_TICK) ? ST_EVAL : ST_IDLE;
                end
                ST_EVAL: begin
                    if (status.abnormal && status.lights_nonzero) begin
                        state_reg <= ST_SEARCH;
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_SEARCH: begin
                    if (status.last_issue) state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (status.pipe_empty) state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (status.out_free) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
